// ----- src/ils_pkg.sv -----
`default_nettype none

package ils_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_ELEM_WIDTH = 32;

   // Fixed port field widths
   localparam int KIND_W   = 3;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH    = 3'd0,
      KIND_INSERT  = 3'd1,
      KIND_REMOVE  = 3'd2,
      KIND_POP     = 3'd3,
      KIND_GET     = 3'd4,
      KIND_REVERSE = 3'd5,
      KIND_CLEAR   = 3'd6
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // Broadcast command to the cell row
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

endpackage : ils_pkg

`default_nettype wire

// ----- src/ils_cell.sv -----
`default_nettype none

module ils_cell #(
   parameter int INDEX      = 0,
   parameter int PHY_W      = 6,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                    clock,
   input  ils_pkg::cell_op_type    cell_op,
   input  logic [PHY_W-1:0]        cell_pos,
   input  logic [ELEM_WIDTH-1:0]   load_value,
   input  logic [ELEM_WIDTH-1:0]   left_value,
   input  logic [ELEM_WIDTH-1:0]   right_value,
   output logic [ELEM_WIDTH-1:0]   value,
   output logic [ELEM_WIDTH-1:0]   read_tap
);

   import ils_pkg::*;

   localparam logic [PHY_W-1:0] MY_INDEX = PHY_W'(INDEX);

   logic [ELEM_WIDTH-1:0] value_ff;
   logic [ELEM_WIDTH-1:0] value_in;
   logic                  at_pos;
   logic                  above_pos;

   assign at_pos    = (MY_INDEX == cell_pos);
   assign above_pos = (MY_INDEX > cell_pos);

   always_comb begin
      value_in = value_ff;
      case (cell_op)
         CELL_INSERT: begin
            if (at_pos) begin
               value_in = load_value;
            end else if (above_pos) begin
               value_in = left_value;
            end
         end
         CELL_REMOVE: begin
            if (at_pos || above_pos) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value    = value_ff;
   assign read_tap = at_pos ? value_ff : '0;

endmodule : ils_cell

`default_nettype wire

// ----- src/indexed_list_store_top.sv -----
`default_nettype none

// Channel   Ports                                        Handshake
// --------  -------------------------------------------  ------------------------------
// request   req_kind, req_position, req_item_value       taken when start && !busy
// response  rsp_read_value, rsp_count, rsp_status        rsp_valid, one cycle, no stall
//
// One item per clock while busy is low: the cell row applies each operation at the edge
// that accepts it, and its response is strobed on the cycle after acceptance.
// busy is high while reset is held and until the first edge that sees reset low;
// reset empties the list and clears the reversal flag, the element words
// themselves are left as they are.
// The receiver cannot stall; each response is shown for its single cycle only.

module indexed_list_store_top #(
   parameter int CAPACITY   = ils_pkg::DEF_CAPACITY,
   parameter int ELEM_WIDTH = ils_pkg::DEF_ELEM_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ils_pkg::KIND_W-1:0]    req_kind,
   input  logic [ils_pkg::POS_W-1:0]     req_position,
   input  logic [ils_pkg::VALUE_W-1:0]   req_item_value,
   output logic                          rsp_valid,
   output logic [ils_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic [ils_pkg::COUNT_W-1:0]   rsp_count,
   output logic [ils_pkg::STATUS_W-1:0]  rsp_status
);

   import ils_pkg::*;

   localparam int PHY_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // List state. The row is kept either in logical order or, after an odd
   // number of reversals, in mirrored order: logical i sits at n-1-i.
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rev_ff, rev_in;
   logic              busy_ff;
   logic              rsp_valid_ff;
   logic [VALUE_W-1:0] read_value_ff, read_value_in;
   status_type        status_ff, status_in;

   logic              accept;
   kind_type          kind;
   logic [CMP_W-1:0]  n_ext;
   logic [CMP_W-1:0]  p_ext;
   logic              list_full;
   logic              get_ok;

   logic [ELEM_WIDTH-1:0] load_value;
   logic [ELEM_WIDTH-1:0] read_any;
   cell_op_type           cell_op;
   logic [PHY_W-1:0]      cell_pos;

   logic [ELEM_WIDTH-1:0] cell_value [CAPACITY];
   logic [ELEM_WIDTH-1:0] cell_tap   [CAPACITY];

   assign accept    = start && !busy_ff;
   assign kind      = kind_type'(req_kind);
   assign n_ext     = CMP_W'(count_ff);
   assign p_ext     = CMP_W'(req_position);
   assign list_full = (count_ff == CNT_W'(CAPACITY));

   // element word in and out at the fixed port widths
   generate
      if (ELEM_WIDTH >= VALUE_W) begin : g_wide
         assign load_value = ELEM_WIDTH'(req_item_value);
      end else begin : g_narrow
         assign load_value = req_item_value[ELEM_WIDTH-1:0];
      end
   endgenerate

   // Decode: status, new count, reversal flag, and the physical slot the row acts on
   always_comb begin
      count_in  = count_ff;
      rev_in    = rev_ff;
      status_in = ST_OK;
      cell_op   = CELL_HOLD;
      cell_pos  = '0;
      get_ok    = 1'b0;
      if (accept) begin
         case (kind)
            KIND_PUSH: begin
               if (list_full) begin
                  status_in = ST_FULL;
               end else begin
                  cell_op  = CELL_INSERT;
                  cell_pos = rev_ff ? '0 : PHY_W'(count_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            KIND_INSERT: begin
               if (p_ext > n_ext) begin
                  status_in = ST_RANGE;
               end else if (list_full) begin
                  status_in = ST_FULL;
               end else begin
                  cell_op  = CELL_INSERT;
                  cell_pos = rev_ff ? PHY_W'(n_ext - p_ext) : PHY_W'(p_ext);
                  count_in = count_ff + 1'b1;
               end
            end
            KIND_REMOVE: begin
               if (p_ext >= n_ext) begin
                  status_in = ST_RANGE;
               end else begin
                  cell_op  = CELL_REMOVE;
                  cell_pos = rev_ff ? PHY_W'(n_ext - p_ext - 1'b1) : PHY_W'(p_ext);
                  count_in = count_ff - 1'b1;
               end
            end
            KIND_POP: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  // mirrored: the last logical entry is slot 0
                  cell_op  = rev_ff ? CELL_REMOVE : CELL_HOLD;
                  count_in = count_ff - 1'b1;
               end
            end
            KIND_GET: begin
               if (p_ext >= n_ext) begin
                  status_in = ST_RANGE;
               end else begin
                  get_ok   = 1'b1;
                  cell_pos = rev_ff ? PHY_W'(n_ext - p_ext - 1'b1) : PHY_W'(p_ext);
               end
            end
            KIND_REVERSE: begin
               rev_in = !rev_ff;
            end
            KIND_CLEAR: begin
               count_in = '0;
               rev_in   = 1'b0;
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   // Cell row; ends of the chain feed back their own word
   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic [ELEM_WIDTH-1:0] left_value;
         logic [ELEM_WIDTH-1:0] right_value;
         if (i == 0) begin : g_first
            assign left_value = cell_value[i];
         end else begin : g_left
            assign left_value = cell_value[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[i];
         end else begin : g_right
            assign right_value = cell_value[i+1];
         end
         ils_cell #(
            .INDEX      (i),
            .PHY_W      (PHY_W),
            .ELEM_WIDTH (ELEM_WIDTH)
         ) u_cell (
            .clock       (clock),
            .cell_op     (cell_op),
            .cell_pos    (cell_pos),
            .load_value  (load_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .read_tap    (cell_tap[i])
         );
      end
   endgenerate

   // only the addressed cell drives a non-zero tap
   always_comb begin
      read_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_any = read_any | cell_tap[i];
      end
   end

   generate
      if (ELEM_WIDTH >= VALUE_W) begin : g_rd_wide
         assign read_value_in = get_ok ? read_any[VALUE_W-1:0] : '0;
      end else begin : g_rd_narrow
         assign read_value_in = get_ok ? VALUE_W'(read_any) : '0;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_value_ff <= read_value_in;
         status_ff     <= status_in;
      end
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = read_value_ff;
   assign rsp_count      = COUNT_W'(count_ff);
   assign rsp_status     = status_ff;

endmodule : indexed_list_store_top

`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ils_pkg::*;

   localparam int CAP = DEF_CAPACITY;
   // kind 7 has no enum member; the block must treat it as a no-op
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

   localparam int NUM_SEGMENTS = 8;
   localparam int SEG_ITEMS    = 165;
   localparam int MAX_GAP      = 16;
   localparam int MAX_REPORTS  = 10;

   // Random segment flavours: which way the list length tends to drift
   localparam int STYLE_FILL     = 0;
   localparam int STYLE_DRAIN    = 1;
   localparam int STYLE_BALANCED = 2;

   // Idle flavours for the request side
   localparam int IDLE_NONE   = 0;
   localparam int IDLE_WIDE   = 1;
   localparam int IDLE_SPARSE = 2;

   typedef struct packed {
      logic [VALUE_W-1:0]  read_value;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } list_result_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] value;
      logic               typed;   // expected result written into the row
      list_result_type    want;
   } stim_row_type;

   // Directed opening. Rows with typed = 1 carry a hand-written result;
   // the others are left to the list predictor.
   stim_row_type directed_rows [25] = '{
      // empty list: every underflow and range case
      '{KIND_POP,     7'd0,   32'h0,        1'b1, '{32'h0,        7'd0, ST_EMPTY}},
      '{KIND_GET,     7'd0,   32'h0,        1'b1, '{32'h0,        7'd0, ST_RANGE}},
      '{KIND_REMOVE,  7'd0,   32'h0,        1'b1, '{32'h0,        7'd0, ST_RANGE}},
      '{KIND_INSERT,  7'd1,   32'h5,        1'b1, '{32'h0,        7'd0, ST_RANGE}},
      '{KIND_REVERSE, 7'd0,   32'h0,        1'b1, '{32'h0,        7'd0, ST_OK}},
      '{KIND_CLEAR,   7'd0,   32'h0,        1'b1, '{32'h0,        7'd0, ST_OK}},
      // build a short list from the value extremes
      '{KIND_PUSH,    7'd0,   32'hFFFFFFFF, 1'b1, '{32'h0,        7'd1, ST_OK}},
      '{KIND_INSERT,  7'd0,   32'h0,        1'b1, '{32'h0,        7'd2, ST_OK}},
      '{KIND_GET,     7'd0,   32'h0,        1'b1, '{32'h0,        7'd2, ST_OK}},
      '{KIND_GET,     7'd1,   32'h0,        1'b1, '{32'hFFFFFFFF, 7'd2, ST_OK}},
      // insert at the end appends, past the end is refused
      '{KIND_INSERT,  7'd2,   32'h12345678, 1'b1, '{32'h0,        7'd3, ST_OK}},
      '{KIND_INSERT,  7'd127, 32'hA5A5A5A5, 1'b1, '{32'h0,        7'd3, ST_RANGE}},
      '{KIND_REVERSE, 7'd0,   32'h0,        1'b1, '{32'h0,        7'd3, ST_OK}},
      '{KIND_GET,     7'd0,   32'h0,        1'b1, '{32'h12345678, 7'd3, ST_OK}},
      '{KIND_GET,     7'd127, 32'h0,        1'b1, '{32'h0,        7'd3, ST_RANGE}},
      '{KIND_REMOVE,  7'd3,   32'h0,        1'b1, '{32'h0,        7'd3, ST_RANGE}},
      '{KIND_REMOVE,  7'd1,   32'h0,        1'b0, '{32'h0,        7'd0, ST_OK}},
      '{KIND_UNUSED,  7'd64,  32'h5A5A5A5A, 1'b1, '{32'h0,        7'd2, ST_OK}},
      '{KIND_PUSH,    7'd0,   32'h80000001, 1'b0, '{32'h0,        7'd0, ST_OK}},
      '{KIND_REVERSE, 7'd0,   32'h0,        1'b0, '{32'h0,        7'd0, ST_OK}},
      '{KIND_GET,     7'd0,   32'h0,        1'b0, '{32'h0,        7'd0, ST_OK}},
      '{KIND_GET,     7'd2,   32'h0,        1'b0, '{32'h0,        7'd0, ST_OK}},
      '{KIND_POP,     7'd0,   32'h0,        1'b0, '{32'h0,        7'd0, ST_OK}},
      '{KIND_REMOVE,  7'd0,   32'h0,        1'b0, '{32'h0,        7'd0, ST_OK}},
      '{KIND_CLEAR,   7'd0,   32'h0,        1'b1, '{32'h0,        7'd0, ST_OK}}
   };

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [KIND_W-1:0]    req_kind;
   logic [POS_W-1:0]     req_position;
   logic [VALUE_W-1:0]   req_item_value;
   logic                 rsp_valid;
   logic [VALUE_W-1:0]   rsp_read_value;
   logic [COUNT_W-1:0]   rsp_count;
   logic [STATUS_W-1:0]  rsp_status;

   // Travel with the item on the request side so the checker knows whether
   // the item came with a hand-written result
   logic                 row_typed;
   list_result_type      row_want;

   // Shadow of the list as the block should hold it
   logic [VALUE_W-1:0]   list_words [CAP];
   int                   list_len;

   list_result_type      pending_results [$];

   int                   failures;
   int                   results_checked;
   int                   items_taken;
   int                   peak_len;
   int                   kind_seen [8];
   int                   status_seen [4];

   indexed_list_store_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_status     (rsp_status)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one operation to the shadow list and returns the result the
   // block must give for it.
   function automatic list_result_type predict_list_op(logic [KIND_W-1:0] k,
                                                       logic [POS_W-1:0] pos,
                                                       logic [VALUE_W-1:0] val);
      list_result_type r;
      int n;
      int p;
      logic [VALUE_W-1:0] t;
      r = '0;
      r.status = ST_OK;
      n = list_len;
      p = int'(pos);
      case (k)
         KIND_PUSH: begin
            if (n >= CAP) r.status = ST_FULL;
            else begin
               list_words[n] = val;
               n++;
            end
         end
         KIND_INSERT: begin
            // range is judged before fullness
            if (p > n) r.status = ST_RANGE;
            else if (n >= CAP) r.status = ST_FULL;
            else begin
               for (int i = n; i > p; i--) list_words[i] = list_words[i-1];
               list_words[p] = val;
               n++;
            end
         end
         KIND_REMOVE: begin
            if (p >= n) r.status = ST_RANGE;
            else begin
               for (int i = p; i + 1 < n; i++) list_words[i] = list_words[i+1];
               n--;
            end
         end
         KIND_POP: begin
            if (n == 0) r.status = ST_EMPTY;
            else n--;
         end
         KIND_GET: begin
            if (p >= n) r.status = ST_RANGE;
            else r.read_value = list_words[p];
         end
         KIND_REVERSE: begin
            for (int i = 0; i < n / 2; i++) begin
               t = list_words[i];
               list_words[i] = list_words[n-1-i];
               list_words[n-1-i] = t;
            end
         end
         KIND_CLEAR: n = 0;
         default: ;
      endcase
      list_len = n;
      r.count = n[COUNT_W-1:0];
      return r;
   endfunction

   // Weighted choice of operation; the weights steer the list length
   function automatic logic [KIND_W-1:0] pick_kind(int style);
      int w [8];
      int r;
      int acc;
      case (style)
         STYLE_FILL:  w = '{40, 30, 6, 4, 12, 4, 1, 3};
         STYLE_DRAIN: w = '{8, 7, 35, 25, 15, 5, 2, 3};
         default:     w = '{20, 20, 15, 10, 20, 8, 3, 4};
      endcase
      r = $urandom_range(0, 99);
      acc = 0;
      for (int i = 0; i < 8; i++) begin
         acc += w[i];
         if (r < acc) return KIND_W'(i);
      end
      return KIND_UNUSED;
   endfunction

   // Mostly in range for the current length, sometimes anything the field holds
   function automatic logic [POS_W-1:0] pick_position(logic [KIND_W-1:0] k);
      if ($urandom_range(0, 99) < 15) return POS_W'($urandom_range(0, 127));
      if (k == KIND_INSERT) return POS_W'($urandom_range(0, list_len));
      if (list_len == 0) return '0;
      return POS_W'($urandom_range(0, list_len - 1));
   endfunction

   task automatic note_failure(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("ERROR: %s", msg);
   endtask

   // Presents one item after an idle gap and holds it until taken.
   // start is only ever written once per falling edge.
   task automatic send_item(logic [KIND_W-1:0] k, logic [POS_W-1:0] p,
                            logic [VALUE_W-1:0] v, int gap,
                            logic typed, list_result_type want);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start          <= 1'b1;
      req_kind       <= k;
      req_position   <= p;
      req_item_value <= v;
      row_typed      <= typed;
      row_want       <= want;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Checker and predictor share one edge: the response seen now belongs to
   // an item taken at an earlier edge, so check first, then predict.
   always @(posedge clock) begin
      list_result_type want;
      if (rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("result with nothing pending: value %h count %0d status %0d",
                                   rsp_read_value, rsp_count, rsp_status));
         end else begin
            want = pending_results.pop_front();
            if (rsp_read_value !== want.read_value || rsp_count !== want.count ||
                rsp_status !== want.status)
               note_failure($sformatf({"result %0d: expected value %h count %0d status %0d,",
                                       " got value %h count %0d status %0d"},
                                      results_checked, want.read_value, want.count,
                                      want.status, rsp_read_value, rsp_count, rsp_status));
            results_checked++;
            if (!$isunknown(rsp_status)) status_seen[rsp_status]++;
         end
      end
      if (reset === 1'b0 && start === 1'b1 && busy === 1'b0) begin
         want = predict_list_op(req_kind, req_position, req_item_value);
         // hand-written rows take precedence; the shadow list still moves
         if (row_typed) want = row_want;
         pending_results.push_back(want);
         items_taken++;
         kind_seen[req_kind]++;
         if (list_len > peak_len) peak_len = list_len;
      end
   end

   // Guard against a hung handshake: well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [KIND_W-1:0]  k;
      logic [POS_W-1:0]   p;
      logic [VALUE_W-1:0] v;
      int style;
      int idle_mode;
      int gap;
      int r;

      clock          = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_kind       = '0;
      req_position   = '0;
      req_item_value = '0;
      row_typed      = 1'b0;
      row_want       = '0;
      list_len       = 0;
      failures       = 0;
      results_checked = 0;
      items_taken    = 0;
      peak_len       = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening; the first item follows reset with no idle gap, after busy has dropped
      foreach (directed_rows[i])
         send_item(directed_rows[i].kind, directed_rows[i].position,
                   directed_rows[i].value, (i == 0) ? 0 : $urandom_range(0, MAX_GAP),
                   directed_rows[i].typed, directed_rows[i].want);

      // random segments: fill pushes the list against its capacity, drain
      // hammers the empty end, balanced wanders in between
      for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
         style = seg % 3;
         idle_mode = (seg % 4 == 0) ? IDLE_NONE : (seg % 4 == 2) ? IDLE_SPARSE : IDLE_WIDE;
         for (int n = 0; n < SEG_ITEMS; n++) begin
            k = pick_kind(style);
            p = pick_position(k);
            r = $urandom_range(0, 99);
            v = (r < 5) ? '0 : (r < 10) ? '1 : $urandom;
            case (idle_mode)
               IDLE_NONE: gap = 0;
               IDLE_WIDE: gap = $urandom_range(0, MAX_GAP);
               default:   gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
            endcase
            send_item(k, p, v, gap, 1'b0, '0);
         end
      end

      @(negedge clock);
      start <= 1'b0;

      // drain: wait until every pending response has been checked
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);

      $display("covered %0d items (%0d directed), %0d results checked, peak length %0d of %0d",
               items_taken, $size(directed_rows), results_checked, peak_len, CAP);
      // kinds push..unused, status ok/range/full/empty
      $display(
         "kind mix %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d, status mix %0d/%0d/%0d/%0d",
         kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
         kind_seen[5], kind_seen[6], kind_seen[7],
         status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d failures", failures);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
